// File: hw/rtl/gam_pkg.sv
// shared types, constants and sizes for the greedy angular matcher
package gam_pkg;

    // store sizes
    localparam int MAX_RECO   = 32;
    localparam int MAX_REF    = 32;
    localparam int RESULT_CAP = 32;

    localparam int RECO_IDX_W = (MAX_RECO > 1) ? $clog2(MAX_RECO) : 1;
    localparam int REF_IDX_W  = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;
    localparam int RECO_CNT_W = $clog2(MAX_RECO + 1);
    localparam int REF_CNT_W  = $clog2(MAX_REF + 1);

    // field widths
    localparam int PT_W    = 16;
    localparam int ETA_W   = 12;
    localparam int PHI_W   = 11;
    localparam int JET_W   = PT_W + ETA_W + PHI_W;
    localparam int DIST_W  = 23;
    localparam int RATIO_W = 10;
    localparam int OIDX_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0]  DIST_SAT        = '1;
    localparam logic [DIST_W-1:0]  DIST_LIMIT_RST  = 23'd3136;
    localparam logic [RATIO_W-1:0] PT_RATIO_RST    = '0;

    // input actions
    localparam logic [1:0] ACT_LOAD_RECO = 2'd0;
    localparam logic [1:0] ACT_LOAD_REF  = 2'd1;
    localparam logic [1:0] ACT_RUN       = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_RATIO   = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT_START,
        ST_EMIT_ISSUE,
        ST_EMIT_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_reco;
        logic load_ref;
        logic scan_clear;
        logic scan_issue;
        logic commit;
        logic emit_clear;
        logic emit_issue;
        logic emit_next;
        logic capture;
        logic run_clear;
    } cmd_t;

    typedef struct packed {
        logic no_reco;
        logic no_ref;
        logic scan_end;
        logic busy;
        logic found;
        logic out_last;
    } status_t;

endpackage

// File: hw/rtl/greedy_angular_matcher.sv
// top level of the greedy angular jet matcher
// Usage:
//   Input channel s_*: action 0 loads a reco jet, 1 a reference jet, 2 runs the
//   matching; action 3 is ignored. A load gives no result;
//   loads into a full store are dropped and reported through m_overflow.
//   Result channel m_*: on a run, one item per reco jet in load order, the last
//   one flagged by m_last; with no reco jets, a single item with m_has_entry 0.
//   Configuration channel cfg_*: always ready; index 0 is the squared distance
//   limit, index 1 the minimum pt ratio. Write only while the block is idle.
// Timing:
//   A run performs greedy rounds; each round streams every reco/reference pair
//   through a three-stage distance pipeline, one pair per cycle; there are at most
//   min(n_reco, n_ref)+1 rounds. Each result is then read back through the
//   pipeline and offered once it drains, held until the receiver takes it.
//   Input is held off (s_ready low) from run start until the last result of
//   the run is taken. A stalled receiver just holds the block in its output
//   state with the result steady.
// Reset: aresetn is synchronous, active low; it empties both stores, clears the
//   overflow flag and restores the register defaults (limit 3136, ratio 0).
module greedy_angular_matcher (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_action,
    input  logic [gam_pkg::PT_W-1:0]         s_jet_pt,
    input  logic signed [gam_pkg::ETA_W-1:0] s_jet_eta,
    input  logic signed [gam_pkg::PHI_W-1:0] s_jet_phi,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [gam_pkg::OIDX_W-1:0]       m_reco_index,
    output logic                             m_has_entry,
    output logic                             m_is_matched,
    output logic [gam_pkg::OIDX_W-1:0]       m_ref_index,
    output logic [gam_pkg::PT_W-1:0]         m_ref_pt,
    output logic [gam_pkg::DIST_W-1:0]       m_dist_sq,
    output logic                             m_overflow,
    output logic                             m_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gam_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gam_pkg::DIST_W-1:0]       cfg_data
);

    gam_pkg::cmd_t    cmd;
    gam_pkg::status_t status;

    assign cfg_ready = 1'b1;

    // controller
    gam_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath
    gam_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_jet_pt     (s_jet_pt),
        .s_jet_eta    (s_jet_eta),
        .s_jet_phi    (s_jet_phi),
        .m_reco_index (m_reco_index),
        .m_has_entry  (m_has_entry),
        .m_is_matched (m_is_matched),
        .m_ref_index  (m_ref_index),
        .m_ref_pt     (m_ref_pt),
        .m_dist_sq    (m_dist_sq),
        .m_overflow   (m_overflow),
        .m_last       (m_last)
    );

`ifndef SYNTHESIS
    // no new item is taken while a result is pending
    a_no_input_during_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input accepted while a result is pending");

    // an empty run gives a single final item
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_entry) |-> (m_last && !m_is_matched))
        else $error("empty run item not marked last");

    // unmatched reco jets carry the saturated distance
    a_unmatched_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_has_entry && !m_is_matched) |-> (m_dist_sq == gam_pkg::DIST_SAT))
        else $error("unmatched item without saturated distance");
`endif

endmodule

// File: hw/rtl/gam_ram.sv
// generic single write port ram with registered read
module gam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: hw/rtl/gam_ctrl.sv
// controller state machine: loads, greedy rounds and result emission
module gam_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_action,
    output logic             m_valid,
    input  logic             m_ready,
    output gam_pkg::cmd_t    cmd,
    input  gam_pkg::status_t status
);

    gam_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gam_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            gam_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_action)
                        gam_pkg::ACT_LOAD_RECO: cmd.load_reco = 1'b1;
                        gam_pkg::ACT_LOAD_REF:  cmd.load_ref = 1'b1;
                        gam_pkg::ACT_RUN:       state_next = gam_pkg::ST_ROUND;
                        default: ;
                    endcase
                end
            end
            gam_pkg::ST_ROUND: begin
                if (status.no_reco || status.no_ref) begin
                    state_next = gam_pkg::ST_EMIT_START;
                end else begin
                    cmd.scan_clear = 1'b1;
                    state_next     = gam_pkg::ST_SCAN;
                end
            end
            gam_pkg::ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (status.scan_end) begin
                    state_next = gam_pkg::ST_DRAIN;
                end
            end
            gam_pkg::ST_DRAIN: begin
                if (!status.busy) begin
                    if (status.found) begin
                        cmd.commit = 1'b1;
                        state_next = gam_pkg::ST_ROUND;
                    end else begin
                        state_next = gam_pkg::ST_EMIT_START;
                    end
                end
            end
            gam_pkg::ST_EMIT_START: begin
                cmd.emit_clear = 1'b1;
                if (status.no_reco) begin
                    cmd.capture = 1'b1;
                    state_next  = gam_pkg::ST_OUT;
                end else begin
                    state_next = gam_pkg::ST_EMIT_ISSUE;
                end
            end
            gam_pkg::ST_EMIT_ISSUE: begin
                cmd.emit_issue = 1'b1;
                state_next     = gam_pkg::ST_EMIT_WAIT;
            end
            gam_pkg::ST_EMIT_WAIT: begin
                if (!status.busy) begin
                    cmd.capture = 1'b1;
                    state_next  = gam_pkg::ST_OUT;
                end
            end
            gam_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.out_last) begin
                        cmd.run_clear = 1'b1;
                        state_next    = gam_pkg::ST_IDLE;
                    end else begin
                        cmd.emit_next = 1'b1;
                        state_next    = gam_pkg::ST_EMIT_ISSUE;
                    end
                end
            end
            default: state_next = gam_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/gam_datapath.sv
// datapath: jet stores, pair distance pipeline, best pair search, result register
module gam_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gam_pkg::cmd_t                       cmd,
    output gam_pkg::status_t                    status,
    input  logic                                cfg_valid,
    input  logic [gam_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gam_pkg::DIST_W-1:0]          cfg_data,
    input  logic [gam_pkg::PT_W-1:0]            s_jet_pt,
    input  logic signed [gam_pkg::ETA_W-1:0]    s_jet_eta,
    input  logic signed [gam_pkg::PHI_W-1:0]    s_jet_phi,
    output logic [gam_pkg::OIDX_W-1:0]          m_reco_index,
    output logic                                m_has_entry,
    output logic                                m_is_matched,
    output logic [gam_pkg::OIDX_W-1:0]          m_ref_index,
    output logic [gam_pkg::PT_W-1:0]            m_ref_pt,
    output logic [gam_pkg::DIST_W-1:0]          m_dist_sq,
    output logic                                m_overflow,
    output logic                                m_last
);

    localparam int RI_W = gam_pkg::RECO_IDX_W;
    localparam int GI_W = gam_pkg::REF_IDX_W;
    localparam int RC_W = gam_pkg::RECO_CNT_W;
    localparam int GC_W = gam_pkg::REF_CNT_W;

    // configuration registers
    logic [gam_pkg::DIST_W-1:0]  limit_reg;
    logic [gam_pkg::RATIO_W-1:0] ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= gam_pkg::DIST_LIMIT_RST;
            ratio_reg <= gam_pkg::PT_RATIO_RST;
        end else if (cfg_valid) begin
            if (cfg_index == gam_pkg::CFG_DIST_LIMIT) begin
                limit_reg <= cfg_data;
            end else if (cfg_index == gam_pkg::CFG_PT_RATIO) begin
                ratio_reg <= cfg_data[gam_pkg::RATIO_W-1:0];
            end
        end
    end

    // counts, taken bits and drop flag
    logic [RC_W-1:0]         reco_cnt_reg;
    logic [GC_W-1:0]         ref_cnt_reg;
    logic                    dropped_reg;
    logic [gam_pkg::MAX_RECO-1:0] reco_taken_reg;
    logic [gam_pkg::MAX_REF-1:0]  ref_taken_reg;
    logic [GI_W-1:0]         assigned_reg [gam_pkg::MAX_RECO];

    logic reco_full, ref_full;
    assign reco_full = (reco_cnt_reg == RC_W'(gam_pkg::MAX_RECO));
    assign ref_full  = (ref_cnt_reg == GC_W'(gam_pkg::MAX_REF));

    // best candidate of the current round
    logic                       found_reg;
    logic [gam_pkg::DIST_W-1:0] best_dist_reg;
    logic [GI_W-1:0]            best_g_reg;
    logic [RI_W-1:0]            best_i_reg;

    // pipeline stage three outputs (declared early for the best update)
    logic                       s3_vld_reg;
    logic                       s3_pass_reg;
    logic [gam_pkg::DIST_W-1:0] s3_dist_reg;
    logic [GI_W-1:0]            s3_g_reg;
    logic [RI_W-1:0]            s3_i_reg;
    logic [gam_pkg::PT_W-1:0]   s3_refpt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reco_cnt_reg   <= '0;
            ref_cnt_reg    <= '0;
            dropped_reg    <= 1'b0;
            reco_taken_reg <= '0;
            ref_taken_reg  <= '0;
        end else begin
            if (cmd.load_reco) begin
                if (reco_full) begin
                    dropped_reg <= 1'b1;
                end else begin
                    reco_cnt_reg <= reco_cnt_reg + RC_W'(1);
                end
            end
            if (cmd.load_ref) begin
                if (ref_full) begin
                    dropped_reg <= 1'b1;
                end else begin
                    ref_cnt_reg <= ref_cnt_reg + GC_W'(1);
                end
            end
            if (cmd.commit) begin
                reco_taken_reg[best_i_reg] <= 1'b1;
                ref_taken_reg[best_g_reg]  <= 1'b1;
            end
            if (cmd.run_clear) begin
                reco_cnt_reg   <= '0;
                ref_cnt_reg    <= '0;
                dropped_reg    <= 1'b0;
                reco_taken_reg <= '0;
                ref_taken_reg  <= '0;
            end
        end
    end

    // assignment table, written on commit
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            assigned_reg[best_i_reg] <= best_g_reg;
        end
    end

    // scan and emit counters
    logic [RI_W-1:0] scan_i_reg;
    logic [GI_W-1:0] scan_g_reg;
    logic [RI_W-1:0] emit_reg;
    logic            scan_i_wrap;

    assign scan_i_wrap = ((RC_W'(scan_i_reg) + RC_W'(1)) == reco_cnt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_i_reg <= '0;
            scan_g_reg <= '0;
            emit_reg   <= '0;
        end else begin
            if (cmd.scan_clear) begin
                scan_i_reg <= '0;
                scan_g_reg <= '0;
            end else if (cmd.scan_issue) begin
                if (scan_i_wrap) begin
                    scan_i_reg <= '0;
                    scan_g_reg <= scan_g_reg + GI_W'(1);
                end else begin
                    scan_i_reg <= scan_i_reg + RI_W'(1);
                end
            end
            if (cmd.emit_clear) begin
                emit_reg <= '0;
            end else if (cmd.emit_next) begin
                emit_reg <= emit_reg + RI_W'(1);
            end
        end
    end

    // jet stores
    logic [gam_pkg::JET_W-1:0] load_word;
    logic [gam_pkg::JET_W-1:0] reco_rd, ref_rd;
    logic [RI_W-1:0]           reco_raddr;
    logic [GI_W-1:0]           ref_raddr;

    assign load_word  = {s_jet_pt, s_jet_eta, s_jet_phi};
    assign reco_raddr = cmd.emit_issue ? emit_reg : scan_i_reg;
    assign ref_raddr  = cmd.emit_issue ? assigned_reg[emit_reg] : scan_g_reg;

    gam_ram #(
        .WIDTH (gam_pkg::JET_W),
        .DEPTH (gam_pkg::MAX_RECO)
    ) u_reco_ram (
        .aclk  (aclk),
        .we    (cmd.load_reco && !reco_full),
        .waddr (reco_cnt_reg[RI_W-1:0]),
        .wdata (load_word),
        .raddr (reco_raddr),
        .rdata (reco_rd)
    );

    gam_ram #(
        .WIDTH (gam_pkg::JET_W),
        .DEPTH (gam_pkg::MAX_REF)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (cmd.load_ref && !ref_full),
        .waddr (ref_cnt_reg[GI_W-1:0]),
        .wdata (load_word),
        .raddr (ref_raddr),
        .rdata (ref_rd)
    );

    // stage one: tags aligned with the ram read data
    logic            s1_vld_reg;
    logic [GI_W-1:0] s1_g_reg;
    logic [RI_W-1:0] s1_i_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= cmd.emit_issue ||
                          (cmd.scan_issue && !ref_taken_reg[scan_g_reg] &&
                           !reco_taken_reg[scan_i_reg]);
        end
        s1_g_reg <= scan_g_reg;
        s1_i_reg <= scan_i_reg;
    end

    // stage two: differences, wrap and squares
    logic signed [gam_pkg::ETA_W-1:0] eta_r, eta_f;
    logic signed [gam_pkg::PHI_W-1:0] phi_r, phi_f;
    logic signed [gam_pkg::ETA_W:0]   deta;
    logic signed [gam_pkg::PHI_W:0]   dphi_raw, dphi;
    logic signed [2*gam_pkg::ETA_W+1:0] deta_sq;
    logic signed [2*gam_pkg::PHI_W+1:0] dphi_sq;
    logic [gam_pkg::RATIO_W+gam_pkg::PT_W-1:0] rhs;

    assign eta_r = reco_rd[gam_pkg::PHI_W +: gam_pkg::ETA_W];
    assign eta_f = ref_rd[gam_pkg::PHI_W +: gam_pkg::ETA_W];
    assign phi_r = reco_rd[gam_pkg::PHI_W-1:0];
    assign phi_f = ref_rd[gam_pkg::PHI_W-1:0];
    assign deta     = {eta_r[gam_pkg::ETA_W-1], eta_r} - {eta_f[gam_pkg::ETA_W-1], eta_f};
    assign dphi_raw = {phi_r[gam_pkg::PHI_W-1], phi_r} - {phi_f[gam_pkg::PHI_W-1], phi_f};

    always_comb begin
        if (dphi_raw >= 12'sd720) begin
            dphi = dphi_raw - 12'sd1440;
        end else if (dphi_raw < -12'sd720) begin
            dphi = dphi_raw + 12'sd1440;
        end else begin
            dphi = dphi_raw;
        end
    end

    assign deta_sq = deta * deta;
    assign dphi_sq = dphi * dphi;
    assign rhs     = ratio_reg * ref_rd[gam_pkg::JET_W-1 -: gam_pkg::PT_W];

    logic                     s2_vld_reg;
    logic [GI_W-1:0]          s2_g_reg;
    logic [RI_W-1:0]          s2_i_reg;
    logic [23:0]              s2_de2_reg;
    logic [18:0]              s2_dp2_reg;
    logic [23:0]              s2_lhs_reg;
    logic [gam_pkg::RATIO_W+gam_pkg::PT_W-1:0] s2_rhs_reg;
    logic [gam_pkg::PT_W-1:0] s2_refpt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else begin
            s2_vld_reg <= s1_vld_reg;
        end
        s2_g_reg     <= s1_g_reg;
        s2_i_reg     <= s1_i_reg;
        s2_de2_reg   <= deta_sq[23:0];
        s2_dp2_reg   <= dphi_sq[18:0];
        s2_lhs_reg   <= {reco_rd[gam_pkg::JET_W-1 -: gam_pkg::PT_W], 8'd0};
        s2_rhs_reg   <= rhs;
        s2_refpt_reg <= ref_rd[gam_pkg::JET_W-1 -: gam_pkg::PT_W];
    end

    // stage three: sum, saturate and candidate test
    logic [24:0]                sum;
    logic [gam_pkg::DIST_W-1:0] pair_dist;
    logic                       pass;

    assign sum       = 25'(s2_de2_reg) + 25'(s2_dp2_reg);
    assign pair_dist = (sum[24:23] != 2'd0) ? gam_pkg::DIST_SAT : sum[22:0];
    assign pass      = ({2'd0, s2_lhs_reg} > s2_rhs_reg) && (pair_dist < limit_reg);

    // data held after the last valid pair so the emit capture can read it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else begin
            s3_vld_reg <= s2_vld_reg;
        end
        if (s2_vld_reg) begin
            s3_pass_reg  <= pass;
            s3_dist_reg  <= pair_dist;
            s3_g_reg     <= s2_g_reg;
            s3_i_reg     <= s2_i_reg;
            s3_refpt_reg <= s2_refpt_reg;
        end
    end

    // best pair update, first in scan order wins a tie
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.scan_clear) begin
            found_reg <= 1'b0;
        end else if (s3_vld_reg && s3_pass_reg &&
                     (!found_reg || s3_dist_reg < best_dist_reg)) begin
            found_reg <= 1'b1;
        end
        if (s3_vld_reg && s3_pass_reg && (!found_reg || s3_dist_reg < best_dist_reg)) begin
            best_dist_reg <= s3_dist_reg;
            best_g_reg    <= s3_g_reg;
            best_i_reg    <= s3_i_reg;
        end
    end

    // result register
    logic [RI_W+gam_pkg::OIDX_W-1:0] reco_idx_ext;
    logic [GI_W+gam_pkg::OIDX_W-1:0] ref_idx_ext;
    logic                            emit_last;
    logic                            emit_matched;

    assign reco_idx_ext = {{gam_pkg::OIDX_W{1'b0}}, emit_reg};
    assign ref_idx_ext  = {{gam_pkg::OIDX_W{1'b0}}, assigned_reg[emit_reg]};
    assign emit_last    = ((32'(emit_reg) + 32'd1) == 32'(reco_cnt_reg)) ||
                          ((32'(emit_reg) + 32'd1) == 32'(gam_pkg::RESULT_CAP));
    assign emit_matched = reco_taken_reg[emit_reg];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            m_overflow <= dropped_reg;
            if (reco_cnt_reg == '0) begin
                m_reco_index <= '0;
                m_has_entry  <= 1'b0;
                m_is_matched <= 1'b0;
                m_ref_index  <= '0;
                m_ref_pt     <= '0;
                m_dist_sq    <= '0;
                m_last       <= 1'b1;
            end else begin
                m_reco_index <= reco_idx_ext[gam_pkg::OIDX_W-1:0];
                m_has_entry  <= 1'b1;
                m_is_matched <= emit_matched;
                m_ref_index  <= emit_matched ? ref_idx_ext[gam_pkg::OIDX_W-1:0] : '0;
                m_ref_pt     <= emit_matched ? s3_refpt_reg : '0;
                m_dist_sq    <= emit_matched ? s3_dist_reg : gam_pkg::DIST_SAT;
                m_last       <= emit_last;
            end
        end
    end

    // status to the controller
    assign status.no_reco  = (reco_cnt_reg == '0);
    assign status.no_ref   = (ref_cnt_reg == '0);
    assign status.scan_end = scan_i_wrap &&
                             ((GC_W'(scan_g_reg) + GC_W'(1)) == ref_cnt_reg);
    assign status.busy     = s1_vld_reg || s2_vld_reg || s3_vld_reg;
    assign status.found    = found_reg;
    assign status.out_last = m_last;

endmodule

// File: verif/tb_greedy_angular_matcher.sv
// self-checking testbench for the greedy angular jet matcher
module tb_greedy_angular_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    // sizes taken from the package
    localparam int PT_W      = gam_pkg::PT_W;
    localparam int ETA_W     = gam_pkg::ETA_W;
    localparam int PHI_W     = gam_pkg::PHI_W;
    localparam int OIDX_W    = gam_pkg::OIDX_W;
    localparam int DIST_W    = gam_pkg::DIST_W;
    localparam int RATIO_W   = gam_pkg::RATIO_W;
    localparam int CFG_IDX_W = gam_pkg::CFG_IDX_W;
    localparam int MAX_RECO  = gam_pkg::MAX_RECO;
    localparam int MAX_REF   = gam_pkg::MAX_REF;

    localparam logic [1:0] ACT_IGNORED = 2'd3;
    localparam int IDLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 12;

    typedef struct {
        logic [1:0] action;
        logic [PT_W-1:0] pt;
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
    } jet_item_t;

    typedef struct {
        logic [OIDX_W-1:0] reco_index;
        logic has_entry;
        logic is_matched;
        logic [OIDX_W-1:0] ref_index;
        logic [PT_W-1:0] ref_pt;
        logic [DIST_W-1:0] dist_sq;
        logic overflow;
        logic last;
    } match_result_t;

    typedef struct {
        jet_item_t item;
        logic typed;
        match_result_t res;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_action = '0;
    logic [PT_W-1:0] s_jet_pt = '0;
    logic signed [ETA_W-1:0] s_jet_eta = '0;
    logic signed [PHI_W-1:0] s_jet_phi = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [OIDX_W-1:0] m_reco_index;
    logic m_has_entry;
    logic m_is_matched;
    logic [OIDX_W-1:0] m_ref_index;
    logic [PT_W-1:0] m_ref_pt;
    logic [DIST_W-1:0] m_dist_sq;
    logic m_overflow;
    logic m_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIST_W-1:0] cfg_data = '0;

    greedy_angular_matcher dut (.*);

    // clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [DIST_W-1:0] limit_reg = gam_pkg::DIST_LIMIT_RST;
    logic [RATIO_W-1:0] ratio_reg = gam_pkg::PT_RATIO_RST;
    jet_item_t reco_jets[MAX_RECO];
    jet_item_t ref_jets[MAX_REF];
    int n_reco = 0;
    int n_ref = 0;
    bit reco_busy[MAX_RECO];
    bit ref_busy[MAX_REF];
    int partner[MAX_RECO];
    bit lost_load = 1'b0;

    match_result_t pending_matches[$];
    int errors = 0;
    int items_done = 0;
    int results_seen = 0;
    int runs_done = 0;
    int matched_seen = 0;
    int overflow_seen = 0;
    bit hold_armed = 1'b0;

    function automatic logic [DIST_W-1:0] angular_dist(jet_item_t a, jet_item_t b);
        int de;
        int dp;
        longint s;
        de = int'(a.eta) - int'(b.eta);
        dp = int'(a.phi) - int'(b.phi);
        if (dp >= 720) dp -= 1440;
        else if (dp < -720) dp += 1440;
        s = longint'(de) * de + longint'(dp) * dp;
        return (s > longint'(gam_pkg::DIST_SAT)) ? gam_pkg::DIST_SAT : DIST_W'(s);
    endfunction

    // greedy pairing and result list for one run
    task automatic match_jets();
        bit found;
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] d;
        int bi;
        int bg;
        match_result_t r;
        forever begin
            found = 0;
            best = '0;
            bi = 0;
            bg = 0;
            for (int g = 0; g < n_ref; g++) begin
                if (ref_busy[g]) continue;
                for (int i = 0; i < n_reco; i++) begin
                    if (reco_busy[i]) continue;
                    if (longint'(reco_jets[i].pt) * 256 <= longint'(ratio_reg) * ref_jets[g].pt)
                        continue;
                    d = angular_dist(reco_jets[i], ref_jets[g]);
                    if (d >= limit_reg) continue;
                    if (!found || d < best) begin
                        found = 1;
                        best = d;
                        bi = i;
                        bg = g;
                    end
                end
            end
            if (!found) break;
            reco_busy[bi] = 1;
            ref_busy[bg] = 1;
            partner[bi] = bg;
        end
        if (n_reco == 0) begin
            r = '{default: '0};
            r.overflow = lost_load;
            r.last = 1'b1;
            pending_matches.insert(pending_matches.size(), r);
        end else begin
            for (int i = 0; i < n_reco; i++) begin
                r = '{default: '0};
                r.reco_index = OIDX_W'(i);
                r.has_entry = 1'b1;
                r.dist_sq = gam_pkg::DIST_SAT;
                if (reco_busy[i]) begin
                    r.is_matched = 1'b1;
                    r.ref_index = OIDX_W'(partner[i]);
                    r.ref_pt = ref_jets[partner[i]].pt;
                    r.dist_sq = angular_dist(reco_jets[i], ref_jets[partner[i]]);
                end
                r.overflow = lost_load;
                r.last = (i == n_reco - 1);
                pending_matches.insert(pending_matches.size(), r);
            end
        end
        n_reco = 0;
        n_ref = 0;
        reco_busy = '{default: 0};
        ref_busy = '{default: 0};
        lost_load = 0;
    endtask

    // state update for one accepted item
    task automatic predict_item(jet_item_t it);
        case (it.action)
            gam_pkg::ACT_LOAD_RECO: begin
                if (n_reco >= MAX_RECO) lost_load = 1;
                else reco_jets[n_reco++] = it;
            end
            gam_pkg::ACT_LOAD_REF: begin
                if (n_ref >= MAX_REF) lost_load = 1;
                else ref_jets[n_ref++] = it;
            end
            gam_pkg::ACT_RUN: begin
                runs_done++;
                match_jets();
            end
            default: ;
        endcase
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one item and hold it until taken
    task automatic send_item(jet_item_t it, logic typed, match_result_t tres);
        int g;
        s_valid <= 1'b1;
        s_action <= it.action;
        s_jet_pt <= it.pt;
        s_jet_eta <= it.eta;
        s_jet_phi <= it.phi;
        do @(posedge aclk); while (!s_ready);
        predict_item(it);
        if (it.action != ACT_IGNORED) items_done++;
        if (typed) begin
            void'(pending_matches.pop_back());
            pending_matches.insert(pending_matches.size(), tres);
        end
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == gam_pkg::CFG_DIST_LIMIT) limit_reg = data;
        else if (idx == gam_pkg::CFG_PT_RATIO) ratio_reg = RATIO_W'(data);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // jet scattered around a centre, phi wrapped, eta clamped
    function automatic jet_item_t near_jet(logic [1:0] act, int ceta, int cphi, int spread);
        jet_item_t j;
        int e;
        int p;
        e = ceta + $urandom_range(0, 2 * spread) - spread;
        p = cphi + $urandom_range(0, 2 * spread) - spread;
        if (e > 2047) e = 2047;
        if (e < -2048) e = -2048;
        if (p > 719) p -= 1440;
        if (p < -720) p += 1440;
        j.action = act;
        j.pt = ($urandom_range(0, 2) == 0) ? PT_W'($urandom_range(0, 65535))
                                           : PT_W'($urandom_range(0, 3000));
        j.eta = ETA_W'(e);
        j.phi = PHI_W'(p);
        return j;
    endfunction

    // one event: loads around a few centres, stray jets, then a run
    task automatic send_event(bit big);
        int nrc;
        int nrf;
        int spread;
        int ce[3];
        int cp[3];
        int k;
        jet_item_t j;
        match_result_t none;
        none = '{default: '0};
        nrc = big ? 34 : $urandom_range(0, 7);
        nrf = big ? 34 : $urandom_range(0, 7);
        case ($urandom_range(0, 2))
            0: spread = 0;
            1: spread = 8;
            default: spread = 40;
        endcase
        for (int c = 0; c < 3; c++) begin
            ce[c] = $urandom_range(0, 4095) - 2048;
            cp[c] = $urandom_range(0, 1439) - 720;
        end
        while (nrc + nrf > 0) begin
            k = $urandom_range(0, 2);
            if (nrf == 0 || (nrc > 0 && $urandom_range(0, 1) == 0)) begin
                j = near_jet(gam_pkg::ACT_LOAD_RECO, ce[k], cp[k], spread);
                nrc--;
            end else begin
                j = near_jet(gam_pkg::ACT_LOAD_REF, ce[k], cp[k], spread);
                nrf--;
            end
            if ($urandom_range(0, 7) == 0) begin
                j.eta = ETA_W'($urandom);
                j.phi = PHI_W'($urandom_range(0, 1439) - 720);
            end
            send_item(j, 1'b0, none);
            if ($urandom_range(0, 19) == 0) begin
                j.action = ACT_IGNORED;
                send_item(j, 1'b0, none);
            end
        end
        j = '{gam_pkg::ACT_RUN, PT_W'($urandom), ETA_W'($urandom), PHI_W'($urandom)};
        send_item(j, 1'b0, none);
    endtask

    localparam match_result_t EMPTY_RUN = '{0, 0, 0, 0, 0, 0, 0, 1};

    stim_row_t directed[] = '{
        '{'{gam_pkg::ACT_RUN, 0, 0, 0}, 1, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_RECO, 65535, 2047, 719}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_REF, 0, -2048, -720}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_RUN, 0, 0, 0}, 1, '{0, 1, 0, 0, 0, gam_pkg::DIST_SAT, 0, 1}},
        '{'{gam_pkg::ACT_LOAD_RECO, 100, 0, 719}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_REF, 200, 0, -720}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_RUN, 0, 0, 0}, 1, '{0, 1, 1, 0, 200, 1, 0, 1}},
        '{'{ACT_IGNORED, 65535, -1, -1}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_RUN, 65535, -1, -1}, 1, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_RECO, 1, -2048, -720}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_RECO, 1, -2048, -720}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_REF, 0, -2048, -720}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_REF, 65535, -2048, 719}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_RUN, 0, 0, 0}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_RECO, 40000, 100, 0}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_REF, 40000, 156, 0}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_REF, 40000, 155, 0}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_RUN, 0, 0, 0}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_LOAD_REF, 5, 5, 5}, 0, EMPTY_RUN},
        '{'{gam_pkg::ACT_RUN, 0, 0, 0}, 1, EMPTY_RUN},
        '{'{ACT_IGNORED, 0, 0, 0}, 0, EMPTY_RUN}
    };

    // register settings per phase; the first phase keeps the reset values
    int limit_set[6] = '{3136, 0, 8388607, 8388607, 20000, 1};
    int ratio_set[6] = '{0, 0, 1023, 0, 300, 0};

    // stimulus
    initial begin
        int phase_items;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[r]) send_item(directed[r].item, directed[r].typed, directed[r].res);
        hold_armed = 1'b1;
        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_idle();
                write_reg(gam_pkg::CFG_DIST_LIMIT, DIST_W'(limit_set[p]));
                write_reg(gam_pkg::CFG_PT_RATIO, DIST_W'(ratio_set[p]));
            end
            phase_items = items_done;
            send_event(p == 1);
            while (items_done - phase_items < 65)
                send_event($urandom_range(0, 24) == 0);
        end
        wait_idle();
        $display("run covered %0d items, %0d runs and %0d results (%0d matched, %0d overflow)",
                 items_done, runs_done, results_seen, matched_seen, overflow_seen);
        $display("six register settings, limits 0 to all ones and pt ratios 0 to 1023");
        if (errors == 0) begin
            $display("** greedy_angular_matcher: PASSED **");
        end else begin
            $display("** greedy_angular_matcher: FAILED **");
        end
        $finish;
    end

    // result side: random stalls and one long hold-off
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if (hold_armed && results_seen >= 3) begin
                hold_armed = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                g = gap_len();
                if (g > 0) begin
                    m_ready <= 1'b0;
                    repeat (g) @(posedge aclk);
                end
            end
        end
    end

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
        end
    endtask

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        match_result_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_is_matched) matched_seen++;
            if (m_overflow) overflow_seen++;
            if (pending_matches.size() == 0) begin
                errors++;
                $display("%0t: result item with nothing expected", $realtime);
            end else begin
                e = pending_matches.pop_front();
                check_field("reco_index", e.reco_index, m_reco_index);
                check_field("has_entry", e.has_entry, m_has_entry);
                check_field("is_matched", e.is_matched, m_is_matched);
                check_field("ref_index", e.ref_index, m_ref_index);
                check_field("ref_pt", e.ref_pt, m_ref_pt);
                check_field("dist_sq", e.dist_sq, m_dist_sq);
                check_field("overflow", e.overflow, m_overflow);
                check_field("last", e.last, m_last);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $realtime, IDLE_LIMIT, pending_matches.size());
            $display("** greedy_angular_matcher: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
